[hdl/abre_pkg.sv]
// Package for the adaptive binary range encoder: beat types, state codes,
// context store request bundle and the fixed LPS probability tables.
// No dependencies.
`default_nettype none

package abre_pkg;

  localparam int NUM_CONTEXTS = 128;
  localparam int PENDING_MAX  = 48;

  localparam int CTX_AW      = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int CTX_W       = 7;
  localparam int PEND_W      = 6;
  localparam int FLUSH_BYTES = 5;
  localparam int CNT_W       = 3;

  localparam logic [31:0] RANGE_INIT    = 32'hFFFF_FFFF;
  localparam logic [7:0]  BYTE_ALL_ONES = 8'hFF;
  localparam logic [5:0]  STATE_TOP     = 6'd63;
  localparam logic        KIND_FLUSH    = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [6:0] context_index;
    logic       bin_value;
  } abre_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       pending_overflow;
  } abre_out_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_SUB,
    ALU_ADD
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CTX,
    ST_SUB,
    ST_ADD,
    ST_CARRY,
    ST_ZEROS,
    ST_SHIFT,
    ST_REL,
    ST_FL_HELD,
    ST_FL_LOW
  } abre_state_t;

  typedef struct packed {
    logic              rd_en;
    logic [CTX_AW-1:0] rd_addr;
    logic              wr_en;
    logic [CTX_AW-1:0] wr_addr;
    logic [CTX_W-1:0]  wr_data;
  } ctx_req_t;

  localparam logic [7:0] LPS_WEIGHT [64] = '{
    8'd128, 8'd124, 8'd120, 8'd116, 8'd111, 8'd106, 8'd101, 8'd96,
    8'd91,  8'd86,  8'd81,  8'd76,  8'd71,  8'd66,  8'd62,  8'd58,
    8'd54,  8'd50,  8'd46,  8'd43,  8'd39,  8'd36,  8'd33,  8'd30,
    8'd27,  8'd24,  8'd22,  8'd20,  8'd18,  8'd16,  8'd14,  8'd12,
    8'd10,  8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd4,
    8'd3,   8'd3,   8'd2,   8'd2,   8'd2,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1
  };

  localparam logic [5:0] LPS_NEXT [64] = '{
    6'd0,  6'd0,  6'd1,  6'd2,  6'd2,  6'd4,  6'd4,  6'd5,
    6'd6,  6'd7,  6'd8,  6'd9,  6'd9,  6'd11, 6'd11, 6'd12,
    6'd13, 6'd14, 6'd15, 6'd16, 6'd16, 6'd18, 6'd18, 6'd19,
    6'd19, 6'd21, 6'd21, 6'd22, 6'd22, 6'd23, 6'd23, 6'd24,
    6'd24, 6'd25, 6'd26, 6'd26, 6'd27, 6'd27, 6'd28, 6'd28,
    6'd29, 6'd29, 6'd30, 6'd30, 6'd30, 6'd31, 6'd32, 6'd32,
    6'd33, 6'd33, 6'd33, 6'd34, 6'd34, 6'd35, 6'd35, 6'd35,
    6'd36, 6'd36, 6'd36, 6'd37, 6'd37, 6'd37, 6'd38, 6'd38
  };

endpackage

`default_nettype wire

[hdl/abre_alu.sv]
// Shared arithmetic unit of the encoder: LPS sub-range multiply,
// range subtract and low add with carry out. Depends on abre_pkg.
`default_nettype none

module abre_alu import abre_pkg::*; (
  input  alu_op_t     op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [32:0] res
);

  logic [31:0] prod;

  // 24 x 8 product: upper range bits times LPS weight
  assign prod = 32'(a[31:8] * b[7:0]);

  always_comb begin
    unique case (op)
      ALU_MUL: res = {1'b0, prod};
      ALU_SUB: res = {1'b0, a} - {1'b0, b};
      ALU_ADD: res = {1'b0, a} + {1'b0, b};
      default: res = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/abre_ctx_store.sv]
// Context store: one memory entry per context with a valid bit each,
// so an entry never written reads as state 0, mps 0. Depends on abre_pkg.
`default_nettype none

module abre_ctx_store import abre_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ctx_req_t         req,
  output logic [CTX_W-1:0] rd_data
);

  logic [CTX_W-1:0]        mem [NUM_CONTEXTS];
  logic [NUM_CONTEXTS-1:0] vld_r;
  logic [CTX_W-1:0]        rdata_r;
  logic                    rvld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rvld_r <= vld_r[req.rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

`default_nettype wire

[hdl/adaptive_binary_range_encoder.sv]
// Top level of the adaptive binary range encoder: sequencer, coder state
// and output register. Depends on abre_pkg, abre_alu, abre_ctx_store.
//
//   channel | ports                         | beat
//   --------+-------------------------------+-----------------------------
//   input   | in_valid, in_stall, in_data   | abre_in_t: kind, ctx, bin
//   output  | out_valid, out_stall, out_data| abre_out_t: byte, last, ovf
//
// An encode item runs from accept to ready through accept, context read
// with multiply, subtract and renormalize check, plus the LPS add for an
// LPS bin, a step per renormalizing shift and a step per byte emitted. A
// flush is accepted, then releases each held byte and then the 5 low bytes.
// The steps are set by the single shared ALU and the registered read of the context memory.
// Reset (rst_n low, synchronous) clears the coder and all context valid bits.
// A stalled output holds its beat; the sequencer waits only when it has a
// byte to emit and the output register is still full and stalled.
`default_nettype none

module adaptive_binary_range_encoder import abre_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  abre_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output abre_out_t out_data
);

  abre_state_t state_r, state_nxt;

  logic [31:0]       low_r, low_nxt;
  logic [31:0]       range_r, range_nxt;
  logic [7:0]        cache_r, cache_nxt;
  logic              cvalid_r, cvalid_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]       rlps_r, rlps_nxt;
  logic [31:0]       diff_r, diff_nxt;
  abre_in_t          item_r, item_nxt;
  logic [CTX_AW-1:0] addr_r, addr_nxt;

  logic              out_valid_r, out_valid_nxt;
  abre_out_t         out_data_r, out_data_nxt;

  // shared unit and context store hookup
  alu_op_t           alu_op;
  logic [31:0]       alu_a, alu_b;
  logic [32:0]       alu_res;
  ctx_req_t          ctx_req;
  logic [CTX_W-1:0]  ctx_rdata;

  logic              emit;
  logic [7:0]        emit_byte;
  logic              emit_last;

  logic [5:0]        ctx_st;
  logic              ctx_mps;
  logic [CTX_AW-1:0] idx_clamp;
  logic [7:0]        top_byte;
  logic              shift_needed;
  logic              fin_shift;
  logic              late_byte;
  logic              slot_free;
  logic              held_rest;
  logic [7:0]        held_byte;

  abre_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  abre_ctx_store u_ctx (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ctx_req),
    .rd_data (ctx_rdata)
  );

  assign ctx_st   = ctx_rdata[5:0];
  assign ctx_mps  = ctx_rdata[6];
  assign top_byte = low_r[31:24];

  // renormalize while range sits below 2^24
  assign shift_needed = (range_r[31:24] == 8'h00) && (range_r != 32'h0);
  // one more shift brings range back above the floor
  assign fin_shift    = (range_r[23:16] != 8'h00);
  // two or more shifts still to go and the second top byte is not 0xFF: that
  // second shift releases the byte cached by the first
  assign late_byte    = shift_needed && !fin_shift && (low_r[23:16] != BYTE_ALL_ONES);
  assign slot_free    = !out_valid_r || !out_stall;

  // clamp out-of-range contexts to the last one
  always_comb begin
    if (32'(in_data.context_index) >= 32'(NUM_CONTEXTS)) begin
      idx_clamp = CTX_AW'(NUM_CONTEXTS - 1);
    end else begin
      idx_clamp = CTX_AW'(in_data.context_index);
    end
  end

  // next held byte to release: cached byte first, then the 0xFF run
  always_comb begin
    if (cvalid_r) begin
      held_byte = cache_r;
      held_rest = (pend_r != '0);
    end else begin
      held_byte = BYTE_ALL_ONES;
      held_rest = (pend_r != PEND_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      low_r       <= '0;
      range_r     <= RANGE_INIT;
      cache_r     <= '0;
      cvalid_r    <= 1'b0;
      pend_r      <= '0;
      ovf_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_r       <= low_nxt;
      range_r     <= range_nxt;
      cache_r     <= cache_nxt;
      cvalid_r    <= cvalid_nxt;
      pend_r      <= pend_nxt;
      ovf_r       <= ovf_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working payload, no reset needed
  always_ff @(posedge clk) begin
    rlps_r     <= rlps_nxt;
    diff_r     <= diff_nxt;
    item_r     <= item_nxt;
    addr_r     <= addr_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    low_nxt    = low_r;
    range_nxt  = range_r;
    cache_nxt  = cache_r;
    cvalid_nxt = cvalid_r;
    pend_nxt   = pend_r;
    ovf_nxt    = ovf_r;
    cnt_nxt    = cnt_r;
    rlps_nxt   = rlps_r;
    diff_nxt   = diff_r;
    item_nxt   = item_r;
    addr_nxt   = addr_r;
    emit       = 1'b0;
    emit_byte  = '0;
    emit_last  = 1'b0;
    alu_op     = ALU_MUL;
    alu_a      = range_r;
    alu_b      = {24'h0, LPS_WEIGHT[ctx_st]};
    ctx_req    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          addr_nxt = idx_clamp;
          cnt_nxt  = CNT_W'(FLUSH_BYTES);
          if (in_data.kind == KIND_FLUSH) begin
            state_nxt = (cvalid_r || pend_r != '0) ? ST_FL_HELD : ST_FL_LOW;
          end else begin
            ctx_req.rd_en   = 1'b1;
            ctx_req.rd_addr = idx_clamp;
            state_nxt       = ST_CTX;
          end
        end
      end

      ST_CTX: begin
        // LPS sub-range from the context just read
        alu_op    = ALU_MUL;
        rlps_nxt  = alu_res[31:0];
        state_nxt = ST_SUB;
      end

      ST_SUB: begin
        alu_op          = ALU_SUB;
        alu_a           = range_r;
        alu_b           = rlps_r;
        ctx_req.wr_en   = 1'b1;
        ctx_req.wr_addr = addr_r;
        if (item_r.bin_value == ctx_mps) begin
          range_nxt = alu_res[31:0];
          ctx_req.wr_data = {ctx_mps,
                             (ctx_st == STATE_TOP) ? STATE_TOP : ctx_st + 6'd1};
          state_nxt = ST_SHIFT;
        end else begin
          diff_nxt  = alu_res[31:0];
          range_nxt = rlps_r;
          ctx_req.wr_data = {(ctx_st == 6'd0) ? ~ctx_mps : ctx_mps,
                             LPS_NEXT[ctx_st]};
          state_nxt = ST_ADD;
        end
      end

      ST_ADD: begin
        alu_op  = ALU_ADD;
        alu_a   = low_r;
        alu_b   = diff_r;
        low_nxt = alu_res[31:0];
        if (alu_res[32] && cvalid_r) begin
          state_nxt = ST_CARRY;
        end else begin
          if (alu_res[32]) begin
            // carry with no cached byte: drop the pending run
            pend_nxt = '0;
          end
          state_nxt = ST_SHIFT;
        end
      end

      ST_CARRY: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_byte  = 8'(cache_r + 8'd1);
          emit_last  = (pend_r == '0) && !late_byte;
          cvalid_nxt = 1'b0;
          state_nxt  = (pend_r == '0) ? ST_SHIFT : ST_ZEROS;
        end
      end

      ST_ZEROS: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = 8'h00;
          emit_last = (pend_r == PEND_W'(1)) && !late_byte;
          pend_nxt  = pend_r - PEND_W'(1);
          if (pend_r == PEND_W'(1)) begin
            state_nxt = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        if (!shift_needed) begin
          state_nxt = ST_IDLE;
        end else if (top_byte == BYTE_ALL_ONES) begin
          // 0xFF may still take a carry: add it to the run, or flag overflow when the run is full
          if (pend_r < PEND_W'(PENDING_MAX)) begin
            pend_nxt = pend_r + PEND_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          low_nxt   = {low_r[23:0], 8'h00};
          range_nxt = {range_r[23:0], 8'h00};
        end else if (cvalid_r || pend_r != '0) begin
          state_nxt = ST_REL;
        end else begin
          cache_nxt  = top_byte;
          cvalid_nxt = 1'b1;
          low_nxt    = {low_r[23:0], 8'h00};
          range_nxt  = {range_r[23:0], 8'h00};
        end
      end

      ST_REL: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = held_byte;
          emit_last = !held_rest && !late_byte;
          if (cvalid_r) begin
            cvalid_nxt = 1'b0;
          end else begin
            pend_nxt = pend_r - PEND_W'(1);
          end
          if (!held_rest) begin
            // all held bytes out: cache the new top byte and shift
            cache_nxt  = top_byte;
            cvalid_nxt = 1'b1;
            low_nxt    = {low_r[23:0], 8'h00};
            range_nxt  = {range_r[23:0], 8'h00};
            state_nxt  = ST_SHIFT;
          end
        end
      end

      ST_FL_HELD: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = held_byte;
          if (cvalid_r) begin
            cvalid_nxt = 1'b0;
          end else begin
            pend_nxt = pend_r - PEND_W'(1);
          end
          if (!held_rest) begin
            state_nxt = ST_FL_LOW;
          end
        end
      end

      ST_FL_LOW: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = top_byte;
          emit_last = (cnt_r == CNT_W'(1));
          low_nxt   = {low_r[23:0], 8'h00};
          cnt_nxt   = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            // restart the coder, keep contexts and the overflow flag
            low_nxt    = '0;
            range_nxt  = RANGE_INIT;
            cache_nxt  = '0;
            cvalid_nxt = 1'b0;
            pend_nxt   = '0;
            state_nxt  = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register: load on emit, drop once taken
  always_comb begin
    out_data_nxt = out_data_r;
    if (emit) begin
      out_valid_nxt                 = 1'b1;
      out_data_nxt.out_byte         = emit_byte;
      out_data_nxt.last             = emit_last;
      out_data_nxt.pending_overflow = ovf_r;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_range_norm: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> range_r[31:24] != 8'h00)
    else $error("range below floor while idle");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(PENDING_MAX))
    else $error("pending run above bound");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r != ST_IDLE)
    else $error("accepted beat did not start work");

  a_flush_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FL_LOW |-> cnt_r != '0)
    else $error("flush byte count exhausted");
`endif

endmodule

`default_nettype wire
